/* rtl/websocket_frame_deframer_defines.svh */
// Assertion macros for the WebSocket frame deframer.
// Included by files that carry concurrent checks; needs no other file.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside reset.
`define WSD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("wsd check failed");

// Checks that a condition never holds outside reset.
`define WSD_ASSERT_NEVER(label, clk, rst_n, cond) \
    `WSD_ASSERT(label, clk, rst_n, !(cond))

`else

`define WSD_ASSERT(label, clk, rst_n, prop)
`define WSD_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

/* rtl/wsd_pkg.sv */
// Shared types and constants for the WebSocket frame deframer.
// Has no dependencies; every module of the block imports it.
package wsd_pkg;

    // Header byte values.
    localparam logic [7:0] FRAME_START    = 8'd129;
    localparam logic [6:0] LEN_DIRECT_MAX = 7'd125;
    localparam logic [6:0] LEN_EXT16      = 7'd126;

    // Extended-length byte counts, minus one.
    localparam logic [2:0] EXT16_LEFT = 3'd1;
    localparam logic [2:0] EXT64_LEFT = 3'd7;

    // Result status codes.
    localparam logic [1:0] ST_DATA  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    // Parser phases.
    typedef enum logic [4:0] {
        PH_FIRST   = 5'b00001,
        PH_LEN     = 5'b00010,
        PH_EXTLEN  = 5'b00100,
        PH_MASK    = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } wsd_phase_t;

    // One result word.
    typedef struct packed {
        logic [7:0] payload_byte;
        logic [1:0] status;
        logic       is_last;
    } wsd_result_t;

endpackage

/* rtl/websocket_frame_deframer.sv */
// WebSocket frame deframer with unmasking, one byte per word.
// Top level; depends on wsd_pkg, wsd_in_reg, wsd_parse, wsd_out_reg and the defines header.
//
// Usage:
// - The slave side takes the received frame stream, one byte per word in tdata.
// - The master side gives at most one result per input word: tdata holds the
//   unmasked payload byte, tuser the status (0 payload, 1 empty frame, 2 bad
//   first byte), and tlast marks the word that ends a frame.
// - Header and key bytes produce no result word, but the last key byte of an empty frame gives the empty-frame word.
// - A result word passes the input register, then the result register, before it is
//   valid; the block takes one byte in every cycle while the receiver does not stall. The per-byte
//   header state update and the 64-bit length countdown sit between the two.
// - When the receiver stalls, the result register holds its word and the input
//   register keeps one more byte; after that s_axis_tready drops.
// - Reset clears both registers and returns the parser to waiting for a frame
//   start byte.
`include "websocket_frame_deframer_defines.svh"

module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // in_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // payload_byte
    output logic [1:0] m_axis_tuser,   // status
    output logic       m_axis_tlast
);

    logic        in_valid;
    logic [7:0]  in_byte;
    logic        load;
    logic        fire;
    logic        res_valid;
    wsd_result_t result;

    // Input byte register.
    wsd_in_reg u_in_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .advance       (load),
        .in_valid      (in_valid),
        .in_byte       (in_byte)
    );

    // A byte is parsed when the result register can take its outcome.
    assign fire = in_valid && load;

    wsd_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .in_byte   (in_byte),
        .res_valid (res_valid),
        .result    (result)
    );

    // Result register.
    wsd_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (fire && res_valid),
        .result        (result),
        .load          (load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Back-pressure on the input only when both stages are full.
    `WSD_ASSERT(a_stall_needs_full, clk, rst_n, !s_axis_tready |-> (in_valid && m_axis_tvalid))
    // Marker and error words carry a zero byte and always end the frame.
    `WSD_ASSERT(a_marker_form, clk, rst_n, (m_axis_tvalid && m_axis_tuser != ST_DATA) |-> (m_axis_tdata == 8'd0 && m_axis_tlast))
    // Status code three is never produced.
    `WSD_ASSERT_NEVER(a_no_bad_status, clk, rst_n, m_axis_tvalid && m_axis_tuser != ST_DATA && m_axis_tuser != ST_EMPTY && m_axis_tuser != ST_BAD)

endmodule

/* rtl/wsd_in_reg.sv */
// Input register stage of the WebSocket frame deframer.
// Depends on wsd_pkg.
module wsd_in_reg
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // in_byte
    input  logic       advance,
    output logic       in_valid,
    output logic [7:0] in_byte
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       take;

    // The stage takes a word when empty or when its word moves on this cycle.
    assign s_axis_tready = !in_valid_reg || advance;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // The data byte needs no reset.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    assign in_valid = in_valid_reg;
    assign in_byte  = in_byte_reg;

endmodule

/* rtl/wsd_parse.sv */
// Frame parser of the WebSocket frame deframer: header, key and unmasking.
// Depends on wsd_pkg.
module wsd_parse
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic [7:0]  in_byte,
    output logic        res_valid,
    output wsd_result_t result
);

    wsd_phase_t  phase_reg, phase_next;
    logic [2:0]  len_left_reg, len_left_next;
    logic [63:0] remaining_reg, remaining_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  key_cnt_reg, key_cnt_next;
    logic [1:0]  idx_reg, idx_next;
    logic [63:0] remaining_dec;
    logic [6:0]  len7;
    logic [7:0]  key_byte;

    assign len7          = in_byte[6:0];
    assign remaining_dec = remaining_reg - 64'd1;

    // Key byte for this payload position; the first key byte sits on top.
    always_comb
    begin
        case (idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // Next state and result for one byte.
    always_comb
    begin
        phase_next     = phase_reg;
        len_left_next  = len_left_reg;
        remaining_next = remaining_reg;
        key_next       = key_reg;
        key_cnt_next   = key_cnt_reg;
        idx_next       = idx_reg;
        res_valid      = 1'b0;
        result         = '{payload_byte: 8'd0, status: ST_DATA, is_last: 1'b0};

        case (phase_reg)
            PH_FIRST:
            begin
                if (in_byte != FRAME_START)
                begin
                    res_valid = 1'b1;
                    result    = '{payload_byte: 8'd0, status: ST_BAD, is_last: 1'b1};
                end
                else
                begin
                    phase_next     = PH_LEN;
                    remaining_next = 64'd0;
                    key_next       = 32'd0;
                    key_cnt_next   = 2'd0;
                    idx_next       = 2'd0;
                    len_left_next  = 3'd0;
                end
            end
            PH_LEN:
            begin
                remaining_next = 64'd0;
                key_cnt_next   = 2'd0;
                if (len7 <= LEN_DIRECT_MAX)
                begin
                    remaining_next = {57'd0, len7};
                    phase_next     = PH_MASK;
                end
                else if (len7 == LEN_EXT16)
                begin
                    len_left_next = EXT16_LEFT;
                    phase_next    = PH_EXTLEN;
                end
                else
                begin
                    len_left_next = EXT64_LEFT;
                    phase_next    = PH_EXTLEN;
                end
            end
            PH_EXTLEN:
            begin
                // Big-endian length bytes shift in from the bottom.
                remaining_next = {remaining_reg[55:0], in_byte};
                if (len_left_reg == 3'd0)
                begin
                    phase_next   = PH_MASK;
                    key_cnt_next = 2'd0;
                end
                else
                begin
                    len_left_next = len_left_reg - 3'd1;
                end
            end
            PH_MASK:
            begin
                key_next = {key_reg[23:0], in_byte};
                if (key_cnt_reg == 2'd3)
                begin
                    key_cnt_next = 2'd0;
                    idx_next     = 2'd0;
                    if (remaining_reg == 64'd0)
                    begin
                        phase_next = PH_FIRST;
                        res_valid  = 1'b1;
                        result     = '{payload_byte: 8'd0, status: ST_EMPTY, is_last: 1'b1};
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                else
                begin
                    key_cnt_next = key_cnt_reg + 2'd1;
                end
            end
            PH_PAYLOAD:
            begin
                idx_next       = idx_reg + 2'd1;
                remaining_next = remaining_dec;
                res_valid      = 1'b1;
                result         = '{payload_byte: in_byte ^ key_byte, status: ST_DATA,
                                   is_last: 1'b0};
                if (remaining_dec == 64'd0)
                begin
                    phase_next     = PH_FIRST;
                    idx_next       = 2'd0;
                    result.is_last = 1'b1;
                end
            end
            default:
            begin
                // An invalid phase code restarts the frame search with this byte.
                phase_next = PH_FIRST;
                if (in_byte != FRAME_START)
                begin
                    res_valid = 1'b1;
                    result    = '{payload_byte: 8'd0, status: ST_BAD, is_last: 1'b1};
                end
                else
                begin
                    phase_next = PH_LEN;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            len_left_reg  <= 3'd0;
            remaining_reg <= 64'd0;
            key_reg       <= 32'd0;
            key_cnt_reg   <= 2'd0;
            idx_reg       <= 2'd0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            len_left_reg  <= len_left_next;
            remaining_reg <= remaining_next;
            key_reg       <= key_next;
            key_cnt_reg   <= key_cnt_next;
            idx_reg       <= idx_next;
        end
    end

endmodule

/* rtl/wsd_out_reg.sv */
// Result register stage of the WebSocket frame deframer.
// Depends on wsd_pkg.
module wsd_out_reg
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        res_valid,
    input  wsd_result_t result,
    output logic        load,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // payload_byte
    output logic [1:0]  m_axis_tuser,   // status
    output logic        m_axis_tlast
);

    logic        out_valid_reg;
    wsd_result_t result_reg;

    // The register can load when empty or when its word leaves this cycle.
    assign load = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = result_reg.payload_byte;
    assign m_axis_tuser  = result_reg.status;
    assign m_axis_tlast  = result_reg.is_last;

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the WebSocket frame deframer.
// Needs wsd_pkg and the websocket_frame_deframer top level.
`timescale 1ns / 1ps

module testbench;
    import wsd_pkg::*;

    // The package has no name for the 64-bit length selector.
    localparam logic [6:0] LEN_EXT64_CODE = 7'd127;
    // Cycles to let pass after the last result before the block is surely idle.
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_BYTES = 300;

    typedef enum logic [1:0] {
        FORM_SHORT,
        FORM_EXT16,
        FORM_EXT64
    } len_form_t;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic       m_axis_tlast;

    // Results that the deframer is due to produce, oldest first.
    wsd_result_t pending_results[$];

    // Mirror of the parser state.
    wsd_phase_t  ph;
    logic [2:0]  ext_left;
    logic [63:0] remaining;
    logic [31:0] key;
    logic [1:0]  key_count;
    logic [1:0]  key_idx;

    int unsigned errors;
    int unsigned bytes_sent;
    int unsigned cycle_count;
    bit          idle_on;

    websocket_frame_deframer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // Advances the parser mirror by one byte and queues any result it causes.
    task automatic deframe_byte(input logic [7:0] b);
        wsd_result_t r;
        logic [7:0]  kb;
        case (ph)
            PH_FIRST:
            begin
                if (b != FRAME_START)
                begin
                    r = '{payload_byte: 8'd0, status: ST_BAD, is_last: 1'b1};
                    pending_results.push_back(r);
                end
                else
                begin
                    ph = PH_LEN;
                    remaining = '0;
                    key = '0;
                    key_count = '0;
                    key_idx = '0;
                    ext_left = '0;
                end
            end
            PH_LEN:
            begin
                remaining = '0;
                // Bit 7 is the mask flag and plays no part.
                if (b[6:0] <= LEN_DIRECT_MAX)
                begin
                    remaining = {57'd0, b[6:0]};
                    ph = PH_MASK;
                end
                else if (b[6:0] == LEN_EXT16)
                begin
                    ext_left = EXT16_LEFT;
                    ph = PH_EXTLEN;
                end
                else
                begin
                    ext_left = EXT64_LEFT;
                    ph = PH_EXTLEN;
                end
                key_count = '0;
            end
            PH_EXTLEN:
            begin
                remaining = {remaining[55:0], b};
                if (ext_left == 3'd0)
                begin
                    ph = PH_MASK;
                    key_count = '0;
                end
                else
                begin
                    ext_left = ext_left - 3'd1;
                end
            end
            PH_MASK:
            begin
                key = {key[23:0], b};
                if (key_count == 2'd3)
                begin
                    key_count = '0;
                    key_idx = '0;
                    if (remaining == 64'd0)
                    begin
                        ph = PH_FIRST;
                        r = '{payload_byte: 8'd0, status: ST_EMPTY, is_last: 1'b1};
                        pending_results.push_back(r);
                    end
                    else
                    begin
                        ph = PH_PAYLOAD;
                    end
                end
                else
                begin
                    key_count = key_count + 2'd1;
                end
            end
            PH_PAYLOAD:
            begin
                kb = key[8 * (3 - key_idx) +: 8];
                key_idx = key_idx + 2'd1;
                remaining = remaining - 64'd1;
                r.payload_byte = b ^ kb;
                r.status = ST_DATA;
                r.is_last = (remaining == 64'd0);
                if (remaining == 64'd0)
                begin
                    ph = PH_FIRST;
                    key_idx = '0;
                end
                pending_results.push_back(r);
            end
            default:
            begin
                // An invalid phase restarts the frame search with this byte.
                ph = PH_FIRST;
                if (b != FRAME_START)
                begin
                    r = '{payload_byte: 8'd0, status: ST_BAD, is_last: 1'b1};
                    pending_results.push_back(r);
                end
                else
                begin
                    ph = PH_LEN;
                end
            end
        endcase
    endtask

    // Sends one byte word, after a random gap while idling is on, and updates the mirror on acceptance.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap != 0)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        deframe_byte(b);
        bytes_sent++;
    endtask

    // A random byte that can never open a frame.
    function automatic logic [7:0] non_start_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == FRAME_START)
            b = b ^ 8'h01;
        return b;
    endfunction

    // Sends a header with the given length field, the key and body_bytes of payload.
    task automatic send_frame(input len_form_t form, input logic [63:0] len,
                              input logic mask_bit, input logic [31:0] mkey,
                              input int unsigned body_bytes);
        send_byte(FRAME_START);
        case (form)
            FORM_SHORT:
            begin
                send_byte({mask_bit, len[6:0]});
            end
            FORM_EXT16:
            begin
                send_byte({mask_bit, LEN_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default:
            begin
                send_byte({mask_bit, LEN_EXT64_CODE});
                for (int i = 7; i >= 0; i--)
                    send_byte(len[8 * i +: 8]);
            end
        endcase
        for (int i = 3; i >= 0; i--)
            send_byte(mkey[8 * i +: 8]);
        for (int unsigned i = 0; i < body_bytes; i++)
            send_byte(8'($urandom));
    endtask

    // Holds the sender until every queued result has been taken, then lets the
    // pipeline empty out behind any header bytes.
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: draws a random stall before each result word while idling is on.
    initial
    begin
        int unsigned stall;
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 7) : 0;
            repeat (stall)
            begin
                @(negedge clk);
                m_axis_tready = 1'b0;
            end
            @(negedge clk);
            m_axis_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    // Compares each accepted result word with the oldest expectation.
    always @(posedge clk)
    begin
        wsd_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result byte=%h status=%0d last=%0d",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.payload_byte || m_axis_tuser !== want.status ||
                    m_axis_tlast !== want.is_last)
                begin
                    errors++;
                    $display("%0t: mismatch expected byte=%h status=%0d last=%0d, got byte=%h status=%0d last=%0d",
                             $time, want.payload_byte, want.status, want.is_last,
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
            end
        end
    end

    // Bytes other than the start value at frame boundaries, extremes included.
    task automatic test_bad_start();
        send_byte(8'd0);
        send_byte(8'hFF);
        send_byte(8'd128);
        send_byte(8'd130);
        send_byte(non_start_byte());
    endtask

    // Empty and short frames, with the mask flag both ways and extreme keys.
    task automatic test_short_frames();
        send_frame(FORM_SHORT, 64'd0, 1'b1, 32'hFFFF_FFFF, 0);
        send_frame(FORM_SHORT, 64'd1, 1'b0, 32'h0000_0000, 1);
        send_frame(FORM_SHORT, 64'd5, 1'b1, 32'hA5C3_0F81, 5);
        // A bad byte right after a frame ends must restart the search.
        send_byte(8'd1);
        send_frame(FORM_SHORT, 64'd2, 1'b0, 32'h1234_5678, 2);
    endtask

    // Largest direct length and both extended forms, empty ones too.
    task automatic test_length_forms();
        send_frame(FORM_SHORT, 64'd125, 1'b1, 32'($urandom), 125);
        send_frame(FORM_EXT16, 64'd0, 1'b1, 32'($urandom), 0);
        send_frame(FORM_EXT16, 64'd3, 1'b0, 32'($urandom), 3);
        send_frame(FORM_EXT16, 64'd258, 1'b1, 32'($urandom), 258);
        send_frame(FORM_EXT64, 64'd0, 1'b0, 32'($urandom), 0);
        send_frame(FORM_EXT64, 64'd6, 1'b1, 32'($urandom), 6);
    endtask

    // Back-to-back words on both sides, with no gaps or stalls.
    task automatic test_full_rate();
        idle_on = 1'b0;
        for (int i = 0; i < 6; i++)
            send_frame(FORM_SHORT, 64'(i * 3), 1'($urandom), 32'($urandom), i * 3);
        send_byte(non_start_byte());
        send_frame(FORM_EXT16, 64'd9, 1'b0, 32'($urandom), 9);
        idle_on = 1'b1;
    endtask

    // Mostly well-formed frames with random content, some noise between them.
    task automatic test_random_frames();
        int unsigned start;
        int unsigned pick;
        int unsigned len;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            // Switch idling on and off now and then.
            if ($urandom_range(0, 19) == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 39) == 0)
                wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                repeat ($urandom_range(1, 3))
                    send_byte(non_start_byte());
            end
            else if (pick < 65)
            begin
                len = $urandom_range(0, 12);
                send_frame(FORM_SHORT, 64'(len), 1'($urandom), 32'($urandom), len);
            end
            else if (pick < 70)
            begin
                len = $urandom_range(13, 125);
                send_frame(FORM_SHORT, 64'(len), 1'($urandom), 32'($urandom), len);
            end
            else if (pick < 84)
            begin
                len = ($urandom_range(0, 29) == 0) ? $urandom_range(200, 300) :
                                                     $urandom_range(0, 20);
                send_frame(FORM_EXT16, 64'(len), 1'($urandom), 32'($urandom), len);
            end
            else
            begin
                len = $urandom_range(0, 20);
                send_frame(FORM_EXT64, 64'(len), 1'($urandom), 32'($urandom), len);
            end
        end
        idle_on = 1'b1;
    endtask

    // A 64-bit length with the top bit set never ends, so this runs last.
    task automatic test_huge_length();
        send_frame(FORM_EXT64, {1'b1, 55'd0, 8'h01}, 1'b1, 32'($urandom), 24);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'd0;
        errors = 0;
        bytes_sent = 0;
        cycle_count = 0;
        idle_on = 1'b1;
        ph = PH_FIRST;
        ext_left = '0;
        remaining = '0;
        key = '0;
        key_count = '0;
        key_idx = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_bad_start();
        test_short_frames();
        wait_drained();
        test_length_forms();
        wait_drained();
        test_full_rate();
        test_random_frames();
        wait_drained();
        test_huge_length();
        wait_drained();

        if (pending_results.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time,
                     pending_results.size());
        end
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
